// ----- rtl/core/occ_pkg.sv -----
// occ_pkg: shared types and constants for the oversampled code correlator.
// Register indexes, widths and reset values, and the response struct.
// No dependencies.
package occ_pkg;

   localparam int CODE_BITS_DEF       = 25;
   localparam int SAMPLES_PER_BIT_DEF = 4;

   localparam int CODE_WIDTH    = 25;
   localparam int COUNT_WIDTH   = 8;
   localparam int TIMER_WIDTH   = 16;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_WIDTH     = CODE_WIDTH;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CODE_PATTERN     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REQUIRED_MATCHES = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIMEOUT_TICKS    = 2'd2;

   localparam logic [CODE_WIDTH-1:0]  CODE_PATTERN_RST     = 25'b0100011011110000110000101;
   localparam logic [COUNT_WIDTH-1:0] REQUIRED_MATCHES_RST = 8'h04;
   localparam logic [TIMER_WIDTH-1:0] TIMEOUT_TICKS_RST    = 16'd2430;

   typedef struct packed {
      logic                   pattern_hit;
      logic [COUNT_WIDTH-1:0] match_count;
      logic                   detected;
   } rsp_type;

endpackage

// ----- rtl/core/occ_corr.sv -----
// occ_corr: sample delay line and parallel compare of the taps against the code.
// Taps are SAMPLES_PER_BIT samples apart; the newest sample is the top tap.
// Depends on occ_pkg.
module occ_corr #(
   parameter int CODE_BITS       = occ_pkg::CODE_BITS_DEF,
   parameter int SAMPLES_PER_BIT = occ_pkg::SAMPLES_PER_BIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift_en,
   input  logic                            sample_bit,
   input  logic [occ_pkg::CODE_WIDTH-1:0]  code_pattern,
   output logic                            match
);

   localparam int LineBits = (CODE_BITS - 1) * SAMPLES_PER_BIT;

   logic [LineBits-1:0]  line_ff;
   logic [LineBits-1:0]  line_in;
   logic [CODE_BITS-1:0] taps;
   logic [31:0]          code_wide;
   logic [CODE_BITS-1:0] code_ext;

   assign code_wide = 32'(code_pattern);
   assign code_ext  = code_wide[CODE_BITS-1:0];

   // line_ff bit 0 is the previous sample; tap CODE_BITS-1-m is m*SAMPLES_PER_BIT samples back
   always_comb begin
      taps[CODE_BITS-1] = sample_bit;
      for (int m = 1; m < CODE_BITS; m++) begin
         taps[CODE_BITS-1-m] = line_ff[m*SAMPLES_PER_BIT-1];
      end
   end

   assign match   = (taps == code_ext);
   assign line_in = (line_ff << 1) | LineBits'(sample_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (shift_en) begin
         line_ff <= line_in;
      end
   end

endmodule

// ----- rtl/core/occ_track.sv -----
// occ_track: confidence count, miss timer and freeze decision per request.
// Produces the response fields for the request in flight.
// Depends on occ_pkg.
module occ_track (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             clear,
   input  logic                             match,
   input  logic [occ_pkg::COUNT_WIDTH-1:0]  required_matches,
   input  logic [occ_pkg::TIMER_WIDTH-1:0]  timeout_ticks,
   output logic                             active,
   output occ_pkg::rsp_type                 result
);

   logic [occ_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [occ_pkg::COUNT_WIDTH-1:0] count_in;
   logic [occ_pkg::COUNT_WIDTH-1:0] count_start;
   logic [occ_pkg::TIMER_WIDTH-1:0] timer_ff;
   logic [occ_pkg::TIMER_WIDTH-1:0] timer_in;
   logic [occ_pkg::TIMER_WIDTH-1:0] timer_inc;

   assign count_start = clear ? '0 : count_ff;
   assign active      = (count_start < required_matches);
   assign timer_inc   = timer_ff + 1'b1;

   always_comb begin
      count_in = count_start;
      timer_in = timer_ff;
      if (active) begin
         if (match) begin
            count_in = count_start + 1'b1;
         end else if (timer_inc > timeout_ticks) begin
            timer_in = '0;
            if (count_start != '0) begin
               count_in = count_start - 1'b1;
            end
         end else begin
            timer_in = timer_inc;
         end
      end
   end

   always_comb begin
      result.pattern_hit = active && match;
      result.match_count = count_in;
      result.detected    = (count_in >= required_matches);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         timer_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         timer_ff <= timer_in;
      end
   end

endmodule

// ----- rtl/core/occ_out_buf.sv -----
// occ_out_buf: two-entry response buffer between the core and the rsp channel.
// Upstream stall comes from the full flag, so it is registered.
// Depends on occ_pkg.
module occ_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  occ_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_stall,
   output occ_pkg::rsp_type out_data
);

   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   occ_pkg::rsp_type slot0_ff;
   occ_pkg::rsp_type slot1_ff;
   logic             pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_data  = slot0_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
         end else if (push) begin
            slot0_ff <= push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= push_data;
         end else begin
            slot1_ff <= push_data;
         end
      end
   end

endmodule

// ----- rtl/core/oversampled_code_correlator.sv -----
// oversampled_code_correlator: top level of the oversampled code correlator.
// Holds the configuration registers and ties delay line, tracker and buffer.
// Depends on occ_pkg, occ_corr, occ_track, occ_out_buf.
//
// Usage:
//   req channel: one request per sample tick (sample bit and clear flag),
//   accepted when req_valid is high and req_stall is low.
//   rsp channel: one response per request (pattern hit, match count,
//   detected), taken when rsp_valid is high and rsp_stall is low.
//   csr port: csr_write_en writes csr_wdata to register csr_index
//   (0 code pattern, 1 required matches, 2 timeout ticks); other indexes
//   are ignored. Write only while no request is in flight.
//   Order: responses are buffered and offered in the order of their requests.
//   Throughput: one request per cycle while req_stall is low; the compare
//   and count update of a request complete in the accepting cycle.
//   Reset: synchronous; clears delay line, count, timer and the response
//   buffer, and loads the register defaults.
//   Stall: a two-entry response buffer absorbs one more request after the
//   receiver stalls; req_stall rises only when both entries are held.
module oversampled_code_correlator #(
   parameter int CODE_BITS       = occ_pkg::CODE_BITS_DEF,
   parameter int SAMPLES_PER_BIT = occ_pkg::SAMPLES_PER_BIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_sample_bit,
   input  logic                               req_clear,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_pattern_hit,
   output logic [occ_pkg::COUNT_WIDTH-1:0]    rsp_match_count,
   output logic                               rsp_detected,
   input  logic                               csr_write_en,
   input  logic [occ_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [occ_pkg::CSR_WIDTH-1:0]      csr_wdata
);

   logic [occ_pkg::CODE_WIDTH-1:0]  code_ff;
   logic [occ_pkg::COUNT_WIDTH-1:0] required_ff;
   logic [occ_pkg::TIMER_WIDTH-1:0] timeout_ff;

   logic             accept;
   logic             active;
   logic             match;
   logic             full;
   occ_pkg::rsp_type result;
   occ_pkg::rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff     <= occ_pkg::CODE_PATTERN_RST;
         required_ff <= occ_pkg::REQUIRED_MATCHES_RST;
         timeout_ff  <= occ_pkg::TIMEOUT_TICKS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            occ_pkg::CSR_CODE_PATTERN: begin
               code_ff <= csr_wdata[occ_pkg::CODE_WIDTH-1:0];
            end
            occ_pkg::CSR_REQUIRED_MATCHES: begin
               required_ff <= csr_wdata[occ_pkg::COUNT_WIDTH-1:0];
            end
            occ_pkg::CSR_TIMEOUT_TICKS: begin
               timeout_ff <= csr_wdata[occ_pkg::TIMER_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   occ_corr #(
      .CODE_BITS       (CODE_BITS),
      .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
   ) u_corr (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (accept && active),
      .sample_bit   (req_sample_bit),
      .code_pattern (code_ff),
      .match        (match)
   );

   occ_track u_track (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .clear            (req_clear),
      .match            (match),
      .required_matches (required_ff),
      .timeout_ticks    (timeout_ff),
      .active           (active),
      .result           (result)
   );

   occ_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_pattern_hit = rsp_data.pattern_hit;
   assign rsp_match_count = rsp_data.match_count;
   assign rsp_detected    = rsp_data.detected;

endmodule

// ----- rtl/core/occ_checker.sv -----
// occ_checker: port-level assertions for the oversampled code correlator.
// Bound to the top level below. Depends on occ_pkg.
module occ_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_pattern_hit,
   input logic [occ_pkg::COUNT_WIDTH-1:0] rsp_match_count,
   input logic                            rsp_detected
);

   // reset empties the response buffer
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("response pending after reset");

   // a hit always leaves a nonzero count
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_hit |-> rsp_match_count != '0)
      else $error("pattern hit with zero match count");

   // stall toward the requester only follows a stalled, held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall && req_valid))
      else $error("request stall without back-pressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pattern_hit)
         && $stable(rsp_match_count) && $stable(rsp_detected))
      else $error("stalled response changed");

endmodule

bind oversampled_code_correlator occ_checker u_occ_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pattern_hit (rsp_pattern_hit),
   .rsp_match_count (rsp_match_count),
   .rsp_detected    (rsp_detected)
);
